### design/bpa_pkg.sv
// Package: shared types, codes and defaults for the buffer pool allocator.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int THREADS_DEF = 4;
	localparam int BUFFERS_DEF = 8;

	localparam int AGE_W = 16;
	localparam logic signed [AGE_W-1:0] AGE_MIN = {1'b1, {(AGE_W-1){1'b0}}};
	localparam logic signed [AGE_W-1:0] AGE_ONE = AGE_W'(1);

	// request kinds
	localparam logic [1:0] KIND_VOL  = 2'd0;
	localparam logic [1:0] KIND_EXCL = 2'd1;
	localparam logic [1:0] KIND_REL  = 2'd2;

	// buffer marks
	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_VOL  = 2'd1;
	localparam logic [1:0] MARK_BUSY = 2'd2;

	// result status
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OUT = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] thread_id;
		logic [2:0] buffer_index;
	} req_t;

	typedef struct packed {
		logic [2:0] granted_index;
		logic       status;
		logic [3:0] free_count;
		logic [3:0] reusable_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]              mark;
		logic signed [AGE_W-1:0] age;
	} entry_t;

endpackage

### design/bpa_mem.sv
// Module: buffer state memory, one write port and one registered read port.
`timescale 1ns / 1ps

module bpa_mem #(
	parameter int DEPTH = bpa_pkg::THREADS_DEF * bpa_pkg::BUFFERS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bpa_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output bpa_pkg::entry_t rdata
);

	bpa_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/bpa_age_alu.sv
// Module: shared signed age subtractor, used for compare and saturating decrement.
`timescale 1ns / 1ps

module bpa_age_alu (
	input  logic signed [bpa_pkg::AGE_W-1:0] a,
	input  logic signed [bpa_pkg::AGE_W-1:0] b,
	output logic                             lt,
	output logic signed [bpa_pkg::AGE_W-1:0] diff_sat
);

	logic [bpa_pkg::AGE_W:0] diff;

	assign diff     = {a[bpa_pkg::AGE_W-1], a} - {b[bpa_pkg::AGE_W-1], b};
	assign lt       = diff[bpa_pkg::AGE_W];
	// hold at the minimum instead of wrapping
	assign diff_sat = (a == bpa_pkg::AGE_MIN) ? a : diff[bpa_pkg::AGE_W-1:0];

endmodule

### design/buffer_pool_allocator_oldest_reuse_top.sv
// Module: top level of the per-thread buffer pool allocator with oldest reuse.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   req     | in        | req_valid/req_stall | bpa_pkg::req_t  (kind, thread, index)
//   rsp     | out       | rsp_valid/rsp_stall | bpa_pkg::rsp_t  (grant, status, counts)
//
// A volatile allocation that finds a buffer makes two passes over the pool through
// the single memory port (scan, then aging); a thread beyond THREADS skips both,
// and every other request makes the scan pass only.
// After reset a clearing pass writes every entry free with age zero;
// req_stall stays high meanwhile.
// req_stall is high whenever the sequencer is busy; a finished response waits
// in its own register, so a new request may be taken while rsp_stall holds it.
`timescale 1ns / 1ps

module buffer_pool_allocator_oldest_reuse_top #(
	parameter int THREADS = bpa_pkg::THREADS_DEF,
	parameter int BUFFERS = bpa_pkg::BUFFERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpa_pkg::rsp_t rsp
);

	localparam int DEPTH = THREADS * BUFFERS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
	localparam int CW    = $clog2(BUFFERS + 1);

	// sequencer states
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_AGE    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] base_q;

	// latched request
	logic [1:0]    kind_q;
	logic [2:0]    bidx_q;
	logic          rel_ok_q;
	logic [BW-1:0] rel_idx_q;

	// scan results
	logic                             free_found_q;
	logic [BW-1:0]                    free_idx_q;
	logic signed [bpa_pkg::AGE_W-1:0] free_age_q;
	logic                             vol_found_q;
	logic [BW-1:0]                    vol_idx_q;
	logic signed [bpa_pkg::AGE_W-1:0] vol_age_q;
	logic [1:0]                       rel_mark_q;
	logic signed [bpa_pkg::AGE_W-1:0] rel_age_q;
	logic [CW-1:0]                    nfree_q;
	logic [CW-1:0]                    nvol_q;

	logic [BW-1:0]  chosen_q;
	bpa_pkg::rsp_t  res_q;
	logic           rsp_valid_q;
	bpa_pkg::rsp_t  rsp_q;

	// memory port
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	bpa_pkg::entry_t mem_wdata;
	logic [AW-1:0]   mem_raddr;
	bpa_pkg::entry_t mem_rdata;

	// shared age unit
	logic signed [bpa_pkg::AGE_W-1:0] alu_b;
	logic                             alu_lt;
	logic signed [bpa_pkg::AGE_W-1:0] alu_dec;

	logic          accept;
	logic          rsp_load;
	logic          ent_vld;
	logic [BW-1:0] ent_idx;
	logic          thread_ok;

	// decision logic
	logic                             found;
	logic [BW-1:0]                    chosen;
	logic signed [bpa_pkg::AGE_W-1:0] chosen_age;
	logic                             dec_we;
	logic [BW-1:0]                    dec_idx;
	bpa_pkg::entry_t                  dec_entry;
	logic [CW-1:0]                    dec_nf;
	logic [CW-1:0]                    dec_nv;
	logic [2:0]                       dec_grant;
	logic                             dec_status;
	logic                             dec_age;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign thread_ok = (32'(req.thread_id) < THREADS);

	// read data of the previous cycle's address belongs to entry cnt-1
	assign ent_vld = (cnt_q != '0);
	assign ent_idx = BW'(cnt_q - CW'(1));

	assign mem_raddr = base_q + AW'(cnt_q);

	bpa_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// compare against the best age during the scan, decrement by one otherwise
	assign alu_b = (state_q == S_SCAN) ? vol_age_q : bpa_pkg::AGE_ONE;

	bpa_age_alu u_alu (
		.a       (mem_rdata.age),
		.b       (alu_b),
		.lt      (alu_lt),
		.diff_sat(alu_dec)
	);

	// Pick the lowest free buffer first, else the oldest (lowest-aged) volatile one,
	// and work out how the counts move for the request kind.
	always_comb begin
		found      = free_found_q || vol_found_q;
		chosen     = free_found_q ? free_idx_q : vol_idx_q;
		chosen_age = free_found_q ? free_age_q : vol_age_q;
		dec_we     = 1'b0;
		dec_idx    = chosen;
		dec_entry  = '{mark: bpa_pkg::MARK_BUSY, age: chosen_age};
		dec_nf     = nfree_q;
		dec_nv     = nvol_q;
		dec_grant  = 3'd0;
		dec_status = bpa_pkg::STATUS_OK;
		dec_age    = 1'b0;
		case (kind_q)
			bpa_pkg::KIND_VOL: begin
				if (found) begin
					dec_grant = 3'(chosen);
					dec_age   = 1'b1;
					if (free_found_q) begin
						dec_nf = nfree_q - CW'(1);
						dec_nv = nvol_q + CW'(1);
					end
				end else begin
					dec_status = bpa_pkg::STATUS_OUT;
				end
			end
			bpa_pkg::KIND_EXCL: begin
				if (found) begin
					dec_grant = 3'(chosen);
					dec_we    = 1'b1;
					if (free_found_q) begin
						dec_nf = nfree_q - CW'(1);
					end else begin
						dec_nv = nvol_q - CW'(1);
					end
				end else begin
					dec_status = bpa_pkg::STATUS_OUT;
				end
			end
			bpa_pkg::KIND_REL: begin
				dec_grant = bidx_q;
				if (rel_ok_q) begin
					dec_we    = 1'b1;
					dec_idx   = rel_idx_q;
					dec_entry = '{mark: bpa_pkg::MARK_FREE, age: rel_age_q};
					case (rel_mark_q)
						bpa_pkg::MARK_VOL: begin
							dec_nf = nfree_q + CW'(1);
							dec_nv = nvol_q - CW'(1);
						end
						bpa_pkg::MARK_BUSY: begin
							dec_nf = nfree_q + CW'(1);
						end
						default: begin
						end
					endcase
				end else begin
					dec_status = bpa_pkg::STATUS_OUT;
				end
			end
			default: begin
			end
		endcase
	end

	// Drive the single write port: clearing pass, decision write-back, aging pass.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '{mark: bpa_pkg::MARK_FREE, age: '0};
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_DECIDE: begin
				mem_we    = dec_we;
				mem_waddr = base_q + AW'(dec_idx);
				mem_wdata = dec_entry;
			end
			S_AGE: begin
				mem_we    = ent_vld;
				mem_waddr = base_q + AW'(ent_idx);
				if (ent_idx == chosen_q) begin
					mem_wdata = '{mark: bpa_pkg::MARK_VOL, age: bpa_pkg::AGE_W'(BUFFERS)};
				end else begin
					mem_wdata = '{mark: mem_rdata.mark, age: alu_dec};
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= thread_ok ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (cnt_q == CW'(BUFFERS)) begin
						state_q <= S_DECIDE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DECIDE: begin
					cnt_q   <= '0;
					state_q <= dec_age ? S_AGE : S_FINISH;
				end
				S_AGE: begin
					if (cnt_q == CW'(BUFFERS)) begin
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_FINISH: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the request, gather scan and decision results; no reset needed on payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q       <= req.kind;
				bidx_q       <= req.buffer_index;
				base_q       <= AW'(32'(req.thread_id) * BUFFERS);
				rel_ok_q     <= (req.kind == bpa_pkg::KIND_REL)
				                && (32'(req.buffer_index) < BUFFERS);
				rel_idx_q    <= BW'(req.buffer_index);
				free_found_q <= 1'b0;
				vol_found_q  <= 1'b0;
				vol_age_q    <= '0;
				rel_mark_q   <= bpa_pkg::MARK_FREE;
				nfree_q      <= '0;
				nvol_q       <= '0;
				// out-of-range thread: reject with zero counts
				res_q        <= '{granted_index: 3'd0, status: bpa_pkg::STATUS_OUT,
				                  free_count: 4'd0, reusable_count: 4'd0};
			end
			S_SCAN: begin
				if (ent_vld) begin
					if (mem_rdata.mark == bpa_pkg::MARK_FREE) begin
						nfree_q <= nfree_q + CW'(1);
						if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= ent_idx;
							free_age_q   <= mem_rdata.age;
						end
					end
					if (mem_rdata.mark == bpa_pkg::MARK_VOL) begin
						nvol_q <= nvol_q + CW'(1);
						// strict compare keeps the lowest index on ties
						if (!vol_found_q || alu_lt) begin
							vol_found_q <= 1'b1;
							vol_idx_q   <= ent_idx;
							vol_age_q   <= mem_rdata.age;
						end
					end
					if (ent_idx == rel_idx_q) begin
						rel_mark_q <= mem_rdata.mark;
						rel_age_q  <= mem_rdata.age;
					end
				end
			end
			S_DECIDE: begin
				chosen_q <= chosen;
				res_q    <= '{granted_index: dec_grant, status: dec_status,
				             free_count: 4'(dec_nf), reusable_count: 4'(dec_nf + dec_nv)};
			end
			default: begin
			end
		endcase
	end

	// Output register: load a finished response, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// The sequencer goes busy right after taking a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request accepted but sequencer did not go busy");

	// The memory is written only while clearing, deciding or aging.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_DECIDE || state_q == S_AGE))
		else $error("memory written outside a writing state");

	// Scan counts never exceed the pool size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (int'(nfree_q) + int'(nvol_q) <= BUFFERS))
		else $error("scan counted more buffers than the pool holds");

	// A response appears only out of the finish state.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("response raised outside the finish state");

endmodule

### test/buffer_pool_allocator_oldest_reuse_top_test.sv
// Testbench: self-checking random and directed test of the buffer pool allocator top.
`timescale 1ns / 1ps

module buffer_pool_allocator_oldest_reuse_top_test;
	import bpa_pkg::*;

	localparam int THREADS = THREADS_DEF;
	localparam int BUFFERS = BUFFERS_DEF;
	// the fourth encoding of kind has no meaning; the block must answer it without effect
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 2000;
	// longest transaction is a volatile allocation: two passes plus overhead
	localparam int DRAIN_CYCLES = 2 * BUFFERS + 5 + 20;

	// Track every pool the way the block should, and hold the responses owed.
	class pool_tracker;
		logic [1:0]              mark [THREADS][BUFFERS];
		logic signed [AGE_W-1:0] age  [THREADS][BUFFERS];
		rsp_t                    owed_rsp [$];
		int                      mismatches;

		function new();
			foreach (mark[t, i]) begin
				mark[t][i] = MARK_FREE;
				age[t][i]  = '0;
			end
			mismatches = 0;
		endfunction

		// Apply one accepted request to the pools and queue the response it owes.
		function void take_request(req_t r);
			rsp_t e;
			int   t;
			int   chosen;
			bit   found;
			int   nfree;
			int   nreuse;
			e = '0;
			t = r.thread_id;
			chosen = 0;
			found = 0;
			nfree = 0;
			nreuse = 0;
			if (t >= THREADS) begin
				e.status = STATUS_OUT;
				owed_rsp.push_back(e);
				return;
			end
			case (r.kind)
				KIND_VOL, KIND_EXCL: begin
					// lowest free buffer wins outright
					for (int i = 0; i < BUFFERS; i++)
						if (!found && mark[t][i] == MARK_FREE) begin
							chosen = i;
							found = 1;
						end
					// else the oldest volatile one, lowest index on ties
					if (!found)
						for (int i = 0; i < BUFFERS; i++)
							if (mark[t][i] == MARK_VOL && (!found || age[t][i] < age[t][chosen])) begin
								chosen = i;
								found = 1;
							end
					if (found) begin
						e.granted_index = 3'(chosen);
						if (r.kind == KIND_VOL) begin
							mark[t][chosen] = MARK_VOL;
							for (int i = 0; i < BUFFERS; i++)
								if (age[t][i] > AGE_MIN)
									age[t][i] = age[t][i] - AGE_ONE;
							age[t][chosen] = AGE_W'(BUFFERS);
						end else begin
							mark[t][chosen] = MARK_BUSY;
						end
					end else begin
						e.status = STATUS_OUT;
					end
				end
				KIND_REL: begin
					e.granted_index = r.buffer_index;
					if (r.buffer_index < BUFFERS)
						mark[t][r.buffer_index] = MARK_FREE;
					else
						e.status = STATUS_OUT;
				end
				default: ;
			endcase
			for (int i = 0; i < BUFFERS; i++) begin
				if (mark[t][i] == MARK_FREE) begin
					nfree++;
					nreuse++;
				end else if (mark[t][i] == MARK_VOL) begin
					nreuse++;
				end
			end
			e.free_count     = 4'(nfree);
			e.reusable_count = 4'(nreuse);
			owed_rsp.push_back(e);
		endfunction

		// Mostly name a buffer that is held, so releases do real work.
		function int held_index(int t);
			int held [$];
			for (int i = 0; i < BUFFERS; i++)
				if (mark[t][i] != MARK_FREE)
					held.push_back(i);
			if (held.size() == 0 || $urandom_range(0, 4) == 0)
				return $urandom_range(0, 7);
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (owed_rsp.size() == 0) begin
				$error("response with none outstanding: %p", got);
				mismatches++;
				return;
			end
			e = owed_rsp.pop_front();
			if (got.granted_index !== e.granted_index) begin
				$error("granted_index: expected %0d, actual %0d", e.granted_index, got.granted_index);
				mismatches++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				mismatches++;
			end
			if (got.free_count !== e.free_count) begin
				$error("free_count: expected %0d, actual %0d", e.free_count, got.free_count);
				mismatches++;
			end
			if (got.reusable_count !== e.reusable_count) begin
				$error("reusable_count: expected %0d, actual %0d",
					e.reusable_count, got.reusable_count);
				mismatches++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	pool_tracker tracker = new();

	// sender pacing: transactions left in the current burst, and its gap ceiling
	int burst_left = 0;
	int gap_max = 0;

	buffer_pool_allocator_oldest_reuse_top #(
		.THREADS(THREADS),
		.BUFFERS(BUFFERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Present one request at the current falling edge and hold it until taken.
	// The request stall also covers the clearing pass after reset.
	task automatic send_request(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.take_request(r);
		@(negedge clk);
	endtask

	// Close the burst when it runs out; drop valid only for a nonzero gap so
	// valid is never lowered and raised at the same edge.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic issue(input logic [1:0] kind, input int thread, input int index);
		req_t r;
		r.kind = kind;
		r.thread_id = 2'(thread);
		r.buffer_index = 3'(index);
		send_request(r);
		pace_sender();
	endtask

	// Skew the request mix per phase: balanced, volatile-heavy,
	// exclusive-heavy (drives pools out of buffers) and release-heavy.
	function automatic logic [1:0] draw_kind(int mix);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return KIND_UNUSED;
		case (mix)
			1: return (roll < 70) ? KIND_VOL : (roll < 80) ? KIND_EXCL : KIND_REL;
			2: return (roll < 25) ? KIND_VOL : (roll < 75) ? KIND_EXCL : KIND_REL;
			3: return (roll < 30) ? KIND_VOL : (roll < 45) ? KIND_EXCL : KIND_REL;
			default: return (roll < 45) ? KIND_VOL : (roll < 68) ? KIND_EXCL : KIND_REL;
		endcase
	endfunction

	// Check every response taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	// Receiver stall pattern: phases of no stall, random stall and heavy stall.
	initial begin
		int mode;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(32, 256)) begin
				@(negedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		int mix;
		int thread;
		logic [1:0] kind;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: fill pool 3 exclusively, then run it out of buffers.
		gap_max = 3;
		for (int i = 0; i < BUFFERS; i++)
			issue(KIND_EXCL, 3, 0);
		issue(KIND_VOL, 3, 0);
		issue(KIND_EXCL, 3, 0);
		// release a busy buffer, then the same one again while already free
		issue(KIND_REL, 3, 5);
		issue(KIND_REL, 3, 5);
		issue(KIND_UNUSED, 3, 7);
		// Fill pool 1 with volatile buffers, then reuse the oldest twice.
		for (int i = 0; i < BUFFERS; i++)
			issue(KIND_VOL, 1, 0);
		issue(KIND_VOL, 1, 6);
		issue(KIND_EXCL, 1, 2);
		// release of a never-used top buffer, unused kind on pool 0
		issue(KIND_REL, 2, 7);
		issue(KIND_UNUSED, 0, 0);

		// Random: phases with their own mix and their own idle profile,
		// some of them without sender gaps at all.
		mix = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				mix = $urandom_range(0, 3);
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			// favor one pool so it fills up and ages deeply
			thread = ($urandom_range(0, 1) == 0) ? (n / 100) % THREADS : $urandom_range(0, 3);
			kind = draw_kind(mix);
			if (kind == KIND_REL)
				issue(kind, thread, tracker.held_index(thread));
			else
				issue(kind, thread, $urandom_range(0, 7));
		end
		req_valid <= 1'b0;

		// Drain the owed responses, then watch for strays.
		while (tracker.owed_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
